// File: rtl/core/dcat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcat_pkg : shared types and constants for the drift corrected clock/alarm
// Payload structs, state record, register indexes and small lookup functions.
// ----------------------------------------------------------------------------
package dcat_pkg;

  localparam int NumAlarm = 5;

  // op codes of an input item
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  // menu result codes
  localparam logic [1:0] MENU_IDLE     = 2'd0;
  localparam logic [1:0] MENU_SELECTED = 2'd1;
  localparam logic [1:0] MENU_TIMEOUT  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ALARM_0 = 3'd0;
  localparam logic [2:0] CFG_ALARM_1 = 3'd1;
  localparam logic [2:0] CFG_ALARM_2 = 3'd2;
  localparam logic [2:0] CFG_ALARM_3 = 3'd3;
  localparam logic [2:0] CFG_ALARM_4 = 3'd4;
  localparam logic [2:0] CFG_GAP     = 3'd5;

  localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
  localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
  localparam logic [6:0] FIX_EVERY_THIRD  = 7'd2;
  localparam logic [6:0] FIX_SEVENTH      = 7'd5;
  localparam logic [2:0] FIX_HOUR_COUNT   = 3'd7;

  localparam logic [5:0] RESET_MINUTE = 6'd9;
  localparam logic [4:0] RESET_HOUR   = 5'd18;

  typedef struct packed {
    logic [1:0] op;
    logic       button_pressed;
  } item_t;

  typedef struct packed {
    logic       menu_opened;
    logic       alarm_fired;
    logic [1:0] menu_result;
    logic [7:0] press_count;
    logic       show_time;
    logic [2:0] hour_fives;
    logic [2:0] hour_ones;
    logic [2:0] ten_minute_blinks;
    logic [7:0] armed_minutes;
    logic [4:0] hour;
    logic [5:0] minute;
  } result_t;

  typedef struct packed {
    logic [NumAlarm-1:0][7:0] alarm_minutes;
    logic [6:0]               menu_gap_polls;
  } cfg_t;

  typedef struct packed {
    logic [2:0] tick_eighths;
    logic [5:0] clock_minute;
    logic [4:0] clock_hour;
    logic [2:0] hours_since_fix;
    logic       alarm_enabled;
    logic [7:0] alarm_period;
    logic [2:0] alarm_eighths;
    logic [7:0] alarm_elapsed;
    logic       edge_parity;
    logic       menu_active;
    logic [7:0] poll_count;
    logic [7:0] last_press_poll;
    logic [7:0] presses;
  } state_t;

  localparam state_t STATE_RESET = '{
    tick_eighths:    3'd0,
    clock_minute:    RESET_MINUTE,
    clock_hour:      RESET_HOUR,
    hours_since_fix: 3'd0,
    alarm_enabled:   1'b0,
    alarm_period:    8'd0,
    alarm_eighths:   3'd0,
    alarm_elapsed:   8'd0,
    edge_parity:     1'b0,
    menu_active:     1'b0,
    poll_count:      8'd0,
    last_press_poll: 8'd0,
    presses:         8'd0
  };

  // hour is at most 24 here
  function automatic logic hour_third(input logic [4:0] h);
    logic r;
    case (h) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] hour_fives_of(input logic [4:0] h);
    logic [2:0] r;
    case (h) inside
      [5'd0:5'd4]:   r = 3'd0;
      [5'd5:5'd9]:   r = 3'd1;
      [5'd10:5'd14]: r = 3'd2;
      [5'd15:5'd19]: r = 3'd3;
      [5'd20:5'd24]: r = 3'd4;
      default:       r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] hour_ones_of(input logic [4:0] h);
    logic [2:0] f;
    logic [4:0] base;
    f    = hour_fives_of(h);
    base = {f, 2'b00} + {2'b00, f};
    return 3'(h - base);
  endfunction

  // minute / 10 + 1, modulo 8
  function automatic logic [2:0] ten_blinks_of(input logic [5:0] m);
    logic [2:0] r;
    case (m) inside
      [6'd0:6'd9]:   r = 3'd1;
      [6'd10:6'd19]: r = 3'd2;
      [6'd20:6'd29]: r = 3'd3;
      [6'd30:6'd39]: r = 3'd4;
      [6'd40:6'd49]: r = 3'd5;
      [6'd50:6'd59]: r = 3'd6;
      default:       r = 3'd7;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dcat_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcat_cfg : configuration register file
// Alarm length table and menu gap, written through a plain write port.
// ----------------------------------------------------------------------------
module dcat_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output dcat_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_minutes[0] <= 8'd3;
      cfg.alarm_minutes[1] <= 8'd8;
      cfg.alarm_minutes[2] <= 8'd15;
      cfg.alarm_minutes[3] <= 8'd30;
      cfg.alarm_minutes[4] <= 8'd60;
      cfg.menu_gap_polls   <= 7'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        dcat_pkg::CFG_ALARM_0: cfg.alarm_minutes[0] <= cfg_data;
        dcat_pkg::CFG_ALARM_1: cfg.alarm_minutes[1] <= cfg_data;
        dcat_pkg::CFG_ALARM_2: cfg.alarm_minutes[2] <= cfg_data;
        dcat_pkg::CFG_ALARM_3: cfg.alarm_minutes[3] <= cfg_data;
        dcat_pkg::CFG_ALARM_4: cfg.alarm_minutes[4] <= cfg_data;
        dcat_pkg::CFG_GAP:     cfg.menu_gap_polls   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dcat_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcat_step : next-state and result logic for one item
// Tick, button edge and menu poll handling in one combinational pass.
// ----------------------------------------------------------------------------
module dcat_step (
  input  wire dcat_pkg::state_t  state,
  input  wire dcat_pkg::item_t   item,
  input  wire dcat_pkg::cfg_t    cfg,
  output dcat_pkg::state_t       state_next,
  output dcat_pkg::result_t      result
);

  logic [6:0] m;
  logic [4:0] h;
  logic [7:0] lapse;
  logic [8:0] gap3;
  logic [7:0] presses_inc;
  logic       sel_done;
  logic       sel_timeout;
  logic [7:0] period;
  logic [2:0] table_idx;

  always_comb begin
    state_next  = state;
    result      = '0;
    m           = {1'b0, state.clock_minute};
    h           = state.clock_hour;
    lapse       = '0;
    gap3        = {2'b00, cfg.menu_gap_polls} + {1'b0, cfg.menu_gap_polls, 1'b0};
    presses_inc = state.presses + 8'd1;
    sel_done    = 1'b0;
    sel_timeout = 1'b0;
    period      = cfg.alarm_minutes[0];
    table_idx   = 3'(presses_inc - 8'd2);

    case (item.op)
      dcat_pkg::OP_TICK: begin
        if (!state.menu_active) begin
          state_next.tick_eighths = state.tick_eighths + 3'd1;
          if (state_next.tick_eighths == 3'd0) m = m + 7'd1;
          if (m >= dcat_pkg::MINUTES_PER_HOUR) begin
            h = state.clock_hour + 5'd1;
            state_next.hours_since_fix = state.hours_since_fix + 3'd1;
            if (dcat_pkg::hour_third(h)) m = m + dcat_pkg::FIX_EVERY_THIRD;
            if (state_next.hours_since_fix == dcat_pkg::FIX_HOUR_COUNT) begin
              m = m + dcat_pkg::FIX_SEVENTH;
              state_next.hours_since_fix = 3'd0;
            end
            if (m >= dcat_pkg::MINUTES_PER_HOUR) m = m - dcat_pkg::MINUTES_PER_HOUR;
            if (h >= dcat_pkg::HOURS_PER_DAY) h = 5'd0;
          end
          state_next.clock_minute = m[5:0];
          state_next.clock_hour   = h;

          if (state.alarm_enabled) begin
            state_next.alarm_eighths = state.alarm_eighths + 3'd1;
            if (state_next.alarm_eighths == 3'd0)
              state_next.alarm_elapsed = state.alarm_elapsed + 8'd1;
            if (state_next.alarm_elapsed == state.alarm_period) begin
              result.alarm_fired       = 1'b1;
              state_next.alarm_enabled = 1'b0;
              state_next.alarm_elapsed = 8'd0;
            end
          end
        end
      end

      dcat_pkg::OP_EDGE: begin
        if (!state.menu_active) begin
          state_next.edge_parity = ~state.edge_parity;
          if (!state_next.edge_parity) begin
            state_next.menu_active     = 1'b1;
            state_next.poll_count      = 8'd0;
            state_next.last_press_poll = 8'd0;
            result.menu_opened         = 1'b1;
          end
        end
      end

      dcat_pkg::OP_POLL: begin
        if (state.menu_active) begin
          state_next.poll_count = state.poll_count + 8'd1;
          lapse = state_next.poll_count - state.last_press_poll;
          // both tests look at the press count before this poll's sample
          sel_done    = (lapse > {1'b0, cfg.menu_gap_polls}) && (state.presses != 8'd0);
          sel_timeout = ({1'b0, lapse} > gap3) && (state.presses == 8'd0);
          if (item.button_pressed) begin
            state_next.presses         = presses_inc;
            state_next.last_press_poll = state_next.poll_count;
          end
          if (sel_timeout) begin
            state_next.menu_active = 1'b0;
            result.menu_result     = dcat_pkg::MENU_TIMEOUT;
          end else if (sel_done) begin
            state_next.menu_active = 1'b0;
            result.menu_result     = dcat_pkg::MENU_SELECTED;
            result.press_count     = state_next.presses;
            if (state_next.presses == 8'd1) begin
              result.show_time         = 1'b1;
              result.hour_fives        = dcat_pkg::hour_fives_of(state.clock_hour);
              result.hour_ones         = dcat_pkg::hour_ones_of(state.clock_hour);
              result.ten_minute_blinks = dcat_pkg::ten_blinks_of(state.clock_minute);
            end else begin
              table_idx = 3'(state_next.presses - 8'd2);
              // wrapped-to-zero and seven-plus counts use the first entry
              if (state_next.presses >= 8'd2 && state_next.presses <= 8'd6)
                period = cfg.alarm_minutes[table_idx];
              state_next.alarm_enabled = 1'b1;
              state_next.alarm_period  = period;
              state_next.alarm_elapsed = 8'd0;
              result.armed_minutes     = period;
            end
            state_next.presses = 8'd0;
          end
        end
      end

      default: ;
    endcase

    result.hour   = state_next.clock_hour;
    result.minute = state_next.clock_minute;
  end

endmodule
`default_nettype wire

// File: rtl/core/drift_corrected_clock_alarm_timer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drift_corrected_clock_alarm_timer_core : clock, one-shot alarm and menu
// Time of day with hourly drift fixes, minute alarm and press-count menu.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item (op, button_pressed).
//                    op selects a watchdog tick, a button edge or a menu poll.
//   result channel : result_valid / result_stall / result, one result for
//                    every item, carrying the time of day after that item.
//   cfg port       : cfg_we / cfg_index / cfg_data, alarm table and menu gap.
//                    Write only while no item is in flight.
//   An item transfer fills the input register; result_valid rises when it
//   moves on into the result register. Throughput is one item per cycle
//   unless result_stall holds: the input register feeds a combinational
//   update of the state registers, which loads the result register.
//   When result_stall holds a full result register, the input register is
//   kept and item_stall rises once it is occupied; nothing is dropped.
//   Synchronous reset empties both registers and returns the clock to 18:09
//   with the alarm off, the menu closed and the configuration at defaults.
// ----------------------------------------------------------------------------
module drift_corrected_clock_alarm_timer_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire dcat_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output dcat_pkg::result_t      result,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  dcat_pkg::cfg_t    cfg;
  dcat_pkg::state_t  state;
  dcat_pkg::state_t  state_next;
  dcat_pkg::result_t step_result;
  dcat_pkg::item_t   stage_item;
  logic              stage_valid;
  logic              advance;

  dcat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcat_step u_step (
    .state      (state),
    .item       (stage_item),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (step_result)
  );

  assign advance    = !result_valid || !result_stall;
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      result <= step_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcat_pkg::STATE_RESET;
    end else if (advance && stage_valid) begin
      state <= state_next;
    end
  end

  // a pending item must wait while a finished result is held
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && result_valid && result_stall) |-> item_stall)
    else $error("input register not held behind a stalled result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance) |=> result_valid)
    else $error("processed item produced no result");

  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.alarm_fired) |-> !state.alarm_enabled)
    else $error("alarm still armed after firing");

  a_open_menu: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.menu_opened) |-> (state.menu_active && !state.edge_parity))
    else $error("menu open cue without open menu");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (state.clock_minute < 6'd60) && (state.clock_hour < 5'd24))
    else $error("time of day out of range");

endmodule
`default_nettype wire
